// ----- hw/rtl/i2cms_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Command codes, internal command state, the reset phase length, bit counts
// and the result item type shared by the sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

   // Command codes as they arrive on the request channel.
   localparam logic [2:0] CMD_START = 3'd0;
   localparam logic [2:0] CMD_STOP  = 3'd1;
   localparam logic [2:0] CMD_WRITE = 3'd2;
   localparam logic [2:0] CMD_READ  = 3'd3;
   localparam logic [2:0] CMD_SACK  = 3'd4;
   localparam logic [2:0] CMD_RACK  = 3'd5;

   // Command in progress; the request code plus one, zero when idle.
   typedef enum logic [2:0] {
      ACT_IDLE  = 3'd0,
      ACT_START = 3'd1,
      ACT_STOP  = 3'd2,
      ACT_WRITE = 3'd3,
      ACT_READ  = 3'd4,
      ACT_SACK  = 3'd5,
      ACT_RACK  = 3'd6
   } active_type;

   localparam logic [15:0] PHASE_TICKS_RESET = 16'd100;
   localparam logic [3:0]  WRITE_BITS        = 4'd9;
   localparam logic [3:0]  READ_BITS         = 4'd8;
   localparam logic [3:0]  SACK_BITS         = 4'd1;

   // One result item.
   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       ack_seen;
   } result_type;

endpackage

// ----- hw/rtl/i2c_master_bit_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Throughput: one item per cycle while the skid entry is empty; each result is
// registered in a two-entry output stage (register and skid) that keeps the
// request side moving while one result waits on a stall.
// Reset: synchronous; the sequencer is idle with SCL and SDA released and
// phase_ticks back at 100.
// Each item is one tick of the timebase; the sequencer walks the SCL/SDA phases
// of the active command, holding each phase for phase_ticks ticks.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_top (
   input  logic        clock,
   input  logic        reset,
   // Request channel, one item per tick.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd_valid,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_write_data,
   input  logic        req_ack_level,
   input  logic        req_sda_in,
   // Result channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_scl_out,
   output logic        rsp_sda_out,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_ack_seen,
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_phase_ticks
);

   i2cms_pkg::active_type active_ff, active_in;
   logic [1:0]  phase_ff, phase_in;
   logic [15:0] tick_ff, tick_in;
   logic [3:0]  bits_ff, bits_in;
   logic [7:0]  shift_ff, shift_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        ack_ff, ack_in;
   logic [7:0]  rdata_ff, rdata_in;
   logic [15:0] phase_ticks_ff;

   logic        done;
   logic [15:0] hold;
   logic [16:0] tick_inc;
   logic        expire;
   logic        finished;
   logic [3:0]  bits_inc;
   logic        do_apply;

   i2cms_pkg::result_type result;
   i2cms_pkg::result_type out_ff, skid_ff;
   logic out_valid_ff, skid_valid_ff;
   logic accept, take;

   // Pin levels for a phase of a command.
   function automatic logic [1:0] phase_pins(input i2cms_pkg::active_type act,
                                             input logic [1:0] ph,
                                             input logic msb,
                                             input logic scl,
                                             input logic sda);
      logic [1:0] pins;
      pins = {scl, sda};
      case (act)
         i2cms_pkg::ACT_START: begin
            if (ph == 2'd0) begin
               pins = 2'b11;
            end else if (ph == 2'd1) begin
               pins = {scl, 1'b0};
            end else begin
               pins = {1'b0, sda};
            end
         end
         i2cms_pkg::ACT_STOP: begin
            if (ph == 2'd0) begin
               pins = 2'b10;
            end else begin
               pins = {scl, 1'b1};
            end
         end
         i2cms_pkg::ACT_WRITE, i2cms_pkg::ACT_SACK,
         i2cms_pkg::ACT_READ, i2cms_pkg::ACT_RACK: begin
            if (ph == 2'd0) begin
               if (act == i2cms_pkg::ACT_WRITE || act == i2cms_pkg::ACT_SACK) begin
                  pins = {scl, msb};
               end else begin
                  pins = {scl, 1'b1};
               end
            end else if (ph == 2'd1) begin
               pins = {1'b1, sda};
            end else begin
               pins = {1'b0, sda};
            end
         end
         default: begin
            pins = {scl, sda};
         end
      endcase
      return pins;
   endfunction

   // Configuration register; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= i2cms_pkg::PHASE_TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         phase_ticks_ff <= csr_phase_ticks;
      end
   end

   // Phase timing: a zero setting counts as one tick.
   assign hold     = (phase_ticks_ff == 16'd0) ? 16'd1 : phase_ticks_ff;
   assign tick_inc = {1'b0, tick_ff} + 17'd1;
   assign expire   = tick_inc >= {1'b0, hold};
   assign bits_inc = bits_ff + 4'd1;

   // Next state of the sequencer for one tick.
   always_comb begin
      active_in = active_ff;
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      bits_in   = bits_ff;
      shift_in  = shift_ff;
      ack_in    = ack_ff;
      rdata_in  = rdata_ff;
      finished  = 1'b0;
      do_apply  = 1'b0;
      if (active_ff == i2cms_pkg::ACT_IDLE) begin
         if (req_cmd_valid && req_command <= i2cms_pkg::CMD_RACK) begin
            active_in = i2cms_pkg::active_type'(req_command + 3'd1);
            phase_in  = 2'd0;
            tick_in   = 16'd0;
            bits_in   = 4'd0;
            do_apply  = 1'b1;
            if (req_command == i2cms_pkg::CMD_WRITE) begin
               shift_in = req_write_data;
            end else if (req_command == i2cms_pkg::CMD_SACK) begin
               shift_in = {req_ack_level, 7'd0};
            end else begin
               shift_in = 8'd0;
            end
         end
      end else if (expire) begin
         tick_in = 16'd0;
         if (active_ff == i2cms_pkg::ACT_START) begin
            finished = (phase_ff >= 2'd2);
            phase_in = phase_ff + 2'd1;
         end else if (active_ff == i2cms_pkg::ACT_STOP) begin
            finished = (phase_ff >= 2'd1);
            phase_in = phase_ff + 2'd1;
         end else begin
            // Sample SDA at the end of the SCL-high phase.
            if (phase_ff == 2'd1) begin
               if (active_ff == i2cms_pkg::ACT_READ) begin
                  shift_in = {shift_ff[6:0], req_sda_in};
               end else if (active_ff == i2cms_pkg::ACT_RACK) begin
                  ack_in = req_sda_in;
               end
            end
            if (phase_ff < 2'd2) begin
               phase_in = phase_ff + 2'd1;
            end else if (active_ff == i2cms_pkg::ACT_RACK) begin
               finished = 1'b1;
            end else if (active_ff == i2cms_pkg::ACT_READ) begin
               bits_in = bits_inc;
               if (bits_inc >= i2cms_pkg::READ_BITS) begin
                  rdata_in = shift_ff;
                  finished = 1'b1;
               end else begin
                  phase_in = 2'd1;
               end
            end else begin
               bits_in  = bits_inc;
               shift_in = {shift_ff[6:0], 1'b1};
               if (bits_inc >= ((active_ff == i2cms_pkg::ACT_WRITE) ?
                                i2cms_pkg::WRITE_BITS : i2cms_pkg::SACK_BITS)) begin
                  finished = 1'b1;
               end else begin
                  phase_in = 2'd0;
               end
            end
         end
         if (finished) begin
            active_in = i2cms_pkg::ACT_IDLE;
            phase_in  = 2'd0;
         end else begin
            do_apply = 1'b1;
         end
      end else begin
         tick_in = tick_inc[15:0];
      end
   end

   // Pin levels and the result item for this tick.
   always_comb begin
      {scl_in, sda_in} = {scl_ff, sda_ff};
      if (do_apply) begin
         {scl_in, sda_in} = phase_pins(active_in, phase_in, shift_in[7], scl_ff, sda_ff);
      end
      done               = finished;
      result.scl_out     = scl_in;
      result.sda_out     = sda_in;
      result.busy_res    = (active_in != i2cms_pkg::ACT_IDLE);
      result.done_res    = done;
      result.read_data   = rdata_in;
      result.ack_seen    = ack_in;
   end

   assign accept = req_valid && !req_stall;
   assign take   = out_valid_ff && !rsp_stall;

   // Sequencer state advances once per accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= i2cms_pkg::ACT_IDLE;
         phase_ff  <= 2'd0;
         tick_ff   <= 16'd0;
         bits_ff   <= 4'd0;
         shift_ff  <= 8'd0;
         scl_ff    <= 1'b1;
         sda_ff    <= 1'b1;
         ack_ff    <= 1'b1;
         rdata_ff  <= 8'd0;
      end else if (accept) begin
         active_ff <= active_in;
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         bits_ff   <= bits_in;
         shift_ff  <= shift_in;
         scl_ff    <= scl_in;
         sda_ff    <= sda_in;
         ack_ff    <= ack_in;
         rdata_ff  <= rdata_in;
      end
   end

   // Output register with a skid entry behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (accept) begin
         if (!out_valid_ff || take) begin
            out_ff <= result;
         end else begin
            skid_ff <= result;
         end
      end
   end

   assign req_stall     = skid_valid_ff;
   assign rsp_valid     = out_valid_ff;
   assign rsp_scl_out   = out_ff.scl_out;
   assign rsp_sda_out   = out_ff.sda_out;
   assign rsp_busy_res  = out_ff.busy_res;
   assign rsp_done_res  = out_ff.done_res;
   assign rsp_read_data = out_ff.read_data;
   assign rsp_ack_seen  = out_ff.ack_seen;

   // The skid entry only fills behind a full output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds an item with the output register empty");

   // A finishing command reports itself no longer busy.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.done_res) |-> !out_ff.busy_res)
      else $error("done pulse with busy still high");

   // Idle sequencer keeps its phase and tick counters cleared.
   a_idle_cleared: assert property (@(posedge clock) disable iff (reset)
      (active_ff == i2cms_pkg::ACT_IDLE) |-> (phase_ff == 2'd0 && tick_ff == 16'd0))
      else $error("idle sequencer with a phase or tick count left over");

   // A finished command returns the sequencer to idle on the next edge.
   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && finished) |=> (active_ff == i2cms_pkg::ACT_IDLE))
      else $error("sequencer still active after its command finished");

endmodule

// ----- tb/sv/i2c_master_bit_sequencer_top_tb.sv -----
// ----------------------------------------------------------------------------
// I2C master bit sequencer testbench
// Feeds one timebase tick per request item and predicts the SCL/SDA levels,
// busy, done, read byte and sampled ack for every tick. Each result item is
// compared field by field against the prediction. A directed part covers the
// reset phase length, the byte and ack extremes, every command, ignored codes
// and a zero phase length. A random part follows with mostly well-formed
// transactions and random stalls on both channels.
// ----------------------------------------------------------------------------

// Predicts the pin sequencer tick by tick and checks the result items.
class sequencer_scoreboard;
   i2cms_pkg::result_type expected_q[$];
   int                    failures;
   int                    results_seen;

   logic [15:0]           ticks_per_phase;
   i2cms_pkg::active_type act;
   logic [2:0]            ph;
   logic [15:0]           tick_cnt;
   logic [3:0]            bit_cnt;
   logic [7:0]            shifter;
   logic [7:0]            read_hold;
   logic                  scl;
   logic                  sda;
   logic                  ack_r;

   function new();
      failures        = 0;
      results_seen    = 0;
      ticks_per_phase = i2cms_pkg::PHASE_TICKS_RESET;
      act             = i2cms_pkg::ACT_IDLE;
      ph              = '0;
      tick_cnt        = '0;
      bit_cnt         = '0;
      shifter         = '0;
      read_hold       = '0;
      scl             = 1'b1;
      sda             = 1'b1;
      ack_r           = 1'b1;
   endfunction

   function void set_phase_ticks(input logic [15:0] value);
      ticks_per_phase = value;
   endfunction

   function bit is_busy();
      return act != i2cms_pkg::ACT_IDLE;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   // Pin levels set on the first tick of the current phase.
   function void drive_pins();
      case (act)
         i2cms_pkg::ACT_START: begin
            if (ph == 3'd0) begin
               sda = 1'b1;
               scl = 1'b1;
            end else if (ph == 3'd1) begin
               sda = 1'b0;
            end else begin
               scl = 1'b0;
            end
         end
         i2cms_pkg::ACT_STOP: begin
            if (ph == 3'd0) begin
               sda = 1'b0;
               scl = 1'b1;
            end else begin
               sda = 1'b1;
            end
         end
         default: begin
            if (ph == 3'd0) begin
               sda = (act == i2cms_pkg::ACT_WRITE || act == i2cms_pkg::ACT_SACK) ?
                     shifter[7] : 1'b1;
            end else if (ph == 3'd1) begin
               scl = 1'b1;
            end else begin
               scl = 1'b0;
            end
         end
      endcase
   endfunction

   // Closes the current phase; returns 1 when the command has finished.
   function bit finish_phase(input logic sda_line);
      if (act == i2cms_pkg::ACT_START) begin
         if (ph >= 3'd2) return 1'b1;
         ph = ph + 3'd1;
         return 1'b0;
      end
      if (act == i2cms_pkg::ACT_STOP) begin
         if (ph >= 3'd1) return 1'b1;
         ph = ph + 3'd1;
         return 1'b0;
      end
      // The end of the SCL-high phase is the sampling point.
      if (ph == 3'd1) begin
         if (act == i2cms_pkg::ACT_READ) shifter = {shifter[6:0], sda_line};
         else if (act == i2cms_pkg::ACT_RACK) ack_r = sda_line;
      end
      if (ph < 3'd2) begin
         ph = ph + 3'd1;
         return 1'b0;
      end
      if (act == i2cms_pkg::ACT_RACK) return 1'b1;
      bit_cnt = bit_cnt + 4'd1;
      if (act == i2cms_pkg::ACT_READ) begin
         if (bit_cnt >= i2cms_pkg::READ_BITS) begin
            read_hold = shifter;
            return 1'b1;
         end
         ph = 3'd1;
         return 1'b0;
      end
      // Write and send ack shift in ones so the ninth write bit is released.
      shifter = {shifter[6:0], 1'b1};
      if (bit_cnt >= ((act == i2cms_pkg::ACT_WRITE) ? i2cms_pkg::WRITE_BITS :
                      i2cms_pkg::SACK_BITS)) return 1'b1;
      ph = 3'd0;
      return 1'b0;
   endfunction

   // Advances the prediction by one accepted tick and queues its result.
   function void note_tick(input logic cmd_v, input logic [2:0] cmd,
                           input logic [7:0] wdata, input logic ack_lvl,
                           input logic sda_line);
      i2cms_pkg::result_type r;
      logic [15:0]           hold_len;
      logic                  done;
      done     = 1'b0;
      hold_len = (ticks_per_phase == 16'd0) ? 16'd1 : ticks_per_phase;
      if (act == i2cms_pkg::ACT_IDLE) begin
         if (cmd_v && cmd <= i2cms_pkg::CMD_RACK) begin
            act      = i2cms_pkg::active_type'(cmd + 3'd1);
            ph       = '0;
            tick_cnt = '0;
            bit_cnt  = '0;
            if (act == i2cms_pkg::ACT_WRITE) shifter = wdata;
            else if (act == i2cms_pkg::ACT_SACK) shifter = {ack_lvl, 7'd0};
            else shifter = '0;
            drive_pins();
         end
      end else if ({1'b0, tick_cnt} + 17'd1 >= {1'b0, hold_len}) begin
         tick_cnt = '0;
         if (finish_phase(sda_line)) begin
            act  = i2cms_pkg::ACT_IDLE;
            ph   = '0;
            done = 1'b1;
         end else begin
            drive_pins();
         end
      end else begin
         tick_cnt = tick_cnt + 16'd1;
      end
      r.scl_out   = scl;
      r.sda_out   = sda;
      r.busy_res  = (act != i2cms_pkg::ACT_IDLE);
      r.done_res  = done;
      r.read_data = read_hold;
      r.ack_seen  = ack_r;
      expected_q.push_back(r);
   endfunction

   task report(input string msg);
      failures++;
      $display("ERROR: %s", msg);
   endtask

   task compare_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         report($sformatf("result %0d: %s is %0h, expected %0h", results_seen, name,
                          got, want));
   endtask

   task check_result(input i2cms_pkg::result_type got);
      i2cms_pkg::result_type want;
      results_seen++;
      if (expected_q.size() == 0) begin
         report($sformatf("result %0d arrived with no item outstanding", results_seen));
      end else begin
         want = expected_q.pop_front();
         compare_field("scl_out", 8'(got.scl_out), 8'(want.scl_out));
         compare_field("sda_out", 8'(got.sda_out), 8'(want.sda_out));
         compare_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
         compare_field("done_res", 8'(got.done_res), 8'(want.done_res));
         compare_field("read_data", got.read_data, want.read_data);
         compare_field("ack_seen", 8'(got.ack_seen), 8'(want.ack_seen));
      end
   endtask
endclass

module i2c_master_bit_sequencer_top_tb;

   localparam int         CYCLE_LIMIT = 200000;
   // No new random transaction starts once this many items have been sent.
   localparam int         ITEM_TARGET = 600;
   // Codes outside the command set; the sequencer ignores them.
   localparam logic [2:0] CMD_BAD_LO  = 3'd6;
   localparam logic [2:0] CMD_BAD_HI  = 3'd7;

   typedef enum int {SDA_RANDOM, SDA_LOW, SDA_HIGH} sda_pattern_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_cmd_valid;
   logic [2:0]  req_command;
   logic [7:0]  req_write_data;
   logic        req_ack_level;
   logic        req_sda_in;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_scl_out;
   logic        rsp_sda_out;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [7:0]  rsp_read_data;
   logic        rsp_ack_seen;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_phase_ticks;

   sequencer_scoreboard bus_model;
   bit                  idle_on;
   bit                  noise_on;
   sda_pattern_type     sda_style;
   int                  items_sent;
   int                  cycle_count;
   int                  stall_left;

   i2c_master_bit_sequencer_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd_valid   (req_cmd_valid),
      .req_command     (req_command),
      .req_write_data  (req_write_data),
      .req_ack_level   (req_ack_level),
      .req_sda_in      (req_sda_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_scl_out     (rsp_scl_out),
      .rsp_sda_out     (rsp_sda_out),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_read_data   (rsp_read_data),
      .rsp_ack_seen    (rsp_ack_seen),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_phase_ticks (csr_phase_ticks)
   );

   always #5 clock = ~clock;

   // Cycle limit guard.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("i2c_master_bit_sequencer_top verification failed");
         $finish;
      end
   end

   // Result side: check each accepted item, then stall for a random stretch.
   always @(posedge clock) begin
      i2cms_pkg::result_type got;
      if (reset) begin
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.scl_out   = rsp_scl_out;
            got.sda_out   = rsp_sda_out;
            got.busy_res  = rsp_busy_res;
            got.done_res  = rsp_done_res;
            got.read_data = rsp_read_data;
            got.ack_seen  = rsp_ack_seen;
            bus_model.check_result(got);
            stall_left = idle_on ? $urandom_range(0, 7) : 0;
         end else if (stall_left != 0) begin
            stall_left--;
         end
      end
      rsp_stall <= (stall_left != 0);
   end

   // Sends one tick item after a random gap and updates the prediction once
   // it is accepted. The caller either sends again in the same step or
   // lowers valid through drain_results.
   task automatic send_tick(input logic cmd_v, input logic [2:0] cmd,
                            input logic [7:0] wdata, input logic ack_lvl);
      int   gap;
      logic sda_line;
      gap = idle_on ? $urandom_range(0, 7) : 0;
      case (sda_style)
         SDA_LOW:  sda_line = 1'b0;
         SDA_HIGH: sda_line = 1'b1;
         default:  sda_line = 1'($urandom_range(0, 1));
      endcase
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd_valid  <= cmd_v;
      req_command    <= cmd;
      req_write_data <= wdata;
      req_ack_level  <= ack_lvl;
      req_sda_in     <= sda_line;
      do @(posedge clock); while (req_stall);
      bus_model.note_tick(cmd_v, cmd, wdata, ack_lvl, sda_line);
      items_sent++;
   endtask

   // A tick with no command, or with a random command as noise.
   task automatic idle_tick();
      send_tick(noise_on ? 1'($urandom_range(0, 1)) : 1'b0,
                3'($urandom_range(i2cms_pkg::CMD_START, CMD_BAD_HI)),
                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   // Holds the sender off until every outstanding result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (bus_model.pending() != 0) @(posedge clock);
   endtask

   // Waits out the current command, then offers the new one.
   task automatic run_command(input logic [2:0] cmd, input logic [7:0] wdata,
                              input logic ack_lvl);
      while (bus_model.is_busy()) idle_tick();
      case ($urandom_range(0, 15))
         0: send_tick(1'b1, 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         1: send_tick(1'b0, cmd, wdata, ack_lvl);
         2: drain_results();
         default: ;
      endcase
      send_tick(1'b1, cmd, wdata, ack_lvl);
   endtask

   // The register is only written with the sequencer idle and nothing in flight.
   task automatic write_phase_ticks(input logic [15:0] value);
      while (bus_model.is_busy()) idle_tick();
      drain_results();
      repeat (4) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_phase_ticks <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      bus_model.set_phase_ticks(value);
   endtask

   // Mostly well-formed transfers: start, address, ack, data, stop.
   task automatic run_transaction();
      int  beats;
      int  k;
      bit  reading;
      noise_on  = 1'($urandom_range(0, 1));
      sda_style = sda_pattern_type'($urandom_range(0, 3) % 3);
      if ($urandom_range(0, 5) == 0) begin
         // Broken sequence: commands in arbitrary order.
         repeat ($urandom_range(1, 4))
            run_command(3'($urandom_range(i2cms_pkg::CMD_START, i2cms_pkg::CMD_RACK)),
                        8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
         reading = 1'($urandom_range(0, 1));
         beats   = $urandom_range(1, 3);
         run_command(i2cms_pkg::CMD_START, 8'd0, 1'b0);
         run_command(i2cms_pkg::CMD_WRITE, {7'($urandom_range(0, 127)), reading}, 1'b0);
         run_command(i2cms_pkg::CMD_RACK, 8'd0, 1'b0);
         for (k = 0; k < beats; k++) begin
            if (reading) begin
               run_command(i2cms_pkg::CMD_READ, 8'($urandom_range(0, 255)), 1'b0);
               run_command(i2cms_pkg::CMD_SACK, 8'($urandom_range(0, 255)),
                           (k == beats - 1) ? 1'b1 : 1'($urandom_range(0, 1)));
            end else begin
               run_command(i2cms_pkg::CMD_WRITE, 8'($urandom_range(0, 255)), 1'b0);
               run_command(i2cms_pkg::CMD_RACK, 8'd0, 1'b0);
            end
         end
         // Leaving out the stop gives a repeated start next time.
         if ($urandom_range(0, 3) != 0) run_command(i2cms_pkg::CMD_STOP, 8'd0, 1'b0);
      end
   endtask

   initial begin
      int          seg;
      logic [15:0] ticks;
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd_valid   = 1'b0;
      req_command     = i2cms_pkg::CMD_START;
      req_write_data  = 8'd0;
      req_ack_level   = 1'b0;
      req_sda_in      = 1'b1;
      csr_valid       = 1'b0;
      csr_phase_ticks = 16'd0;
      items_sent      = 0;
      idle_on         = 1'b1;
      noise_on        = 1'b0;
      sda_style       = SDA_RANDOM;
      bus_model       = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset phase length, then byte and ack extremes at one tick.
      run_command(i2cms_pkg::CMD_STOP, 8'd0, 1'b0);
      write_phase_ticks(16'd1);
      sda_style = SDA_LOW;
      run_command(i2cms_pkg::CMD_START, 8'd0, 1'b0);
      run_command(i2cms_pkg::CMD_WRITE, 8'hFF, 1'b0);
      run_command(i2cms_pkg::CMD_RACK, 8'd0, 1'b0);
      sda_style = SDA_HIGH;
      run_command(i2cms_pkg::CMD_WRITE, 8'h00, 1'b1);
      run_command(i2cms_pkg::CMD_RACK, 8'd0, 1'b0);
      run_command(i2cms_pkg::CMD_READ, 8'd0, 1'b0);
      run_command(i2cms_pkg::CMD_SACK, 8'd0, 1'b0);
      sda_style = SDA_LOW;
      run_command(i2cms_pkg::CMD_READ, 8'd0, 1'b0);
      run_command(i2cms_pkg::CMD_SACK, 8'd0, 1'b1);
      // Random commands offered as noise on busy ticks, which may include the done tick.
      noise_on  = 1'b1;
      sda_style = SDA_RANDOM;
      run_command(i2cms_pkg::CMD_WRITE, 8'h80, 1'b0);
      run_command(i2cms_pkg::CMD_READ, 8'd0, 1'b0);
      run_command(i2cms_pkg::CMD_RACK, 8'd0, 1'b0);
      send_tick(1'b1, CMD_BAD_LO, 8'hA5, 1'b1);
      send_tick(1'b1, CMD_BAD_HI, 8'h5A, 1'b0);
      run_command(i2cms_pkg::CMD_STOP, 8'd0, 1'b0);
      // A zero phase length behaves as one tick; both sides at full rate.
      write_phase_ticks(16'd0);
      idle_on = 1'b0;
      run_command(i2cms_pkg::CMD_START, 8'd0, 1'b0);
      run_command(i2cms_pkg::CMD_WRITE, 8'h01, 1'b0);
      run_command(i2cms_pkg::CMD_RACK, 8'd0, 1'b0);
      run_command(i2cms_pkg::CMD_STOP, 8'd0, 1'b0);
      idle_on = 1'b1;

      // Random transactions over several phase lengths.
      seg = 0;
      while (items_sent < ITEM_TARGET) begin
         if (seg % 3 == 1) ticks = 16'd0;
         else ticks = 16'($urandom_range(1, 2));
         write_phase_ticks(ticks);
         idle_on = (seg % 4) != 2;
         run_transaction();
         seg++;
      end

      while (bus_model.is_busy()) idle_tick();
      drain_results();
      repeat (8) @(posedge clock);
      if (bus_model.failures == 0) begin
         $display("i2c_master_bit_sequencer_top verification clean");
      end else begin
         $display("i2c_master_bit_sequencer_top verification failed");
      end
      $finish;
   end

endmodule
